/* rtl/ftd_pkg.sv */
// ----------------------------------------------------------------------------
// ftd_pkg
// Shared types and constants for the file transfer deframer: event codes,
// parser phases and the result record passed from the parser to the output.
// ----------------------------------------------------------------------------
package ftd_pkg;

  localparam logic [31:0] FRAME_MAGIC_RESET = 32'h4E46544C;

  localparam int unsigned MAGIC_BYTES = 4;
  localparam int unsigned LEN_BYTES   = 4;
  localparam int unsigned SIZE_BYTES  = 8;

  typedef enum logic [2:0] {
    EV_NAME      = 3'd0,
    EV_HEADER    = 3'd1,
    EV_PAYLOAD   = 3'd2,
    EV_ACK       = 3'd3,
    EV_BAD_MAGIC = 3'd4,
    EV_BAD_TYPE  = 3'd5
  } event_t;

  typedef enum logic [5:0] {
    PH_PREFIX    = 6'b000001,
    PH_NAME_LEN  = 6'b000010,
    PH_SIZE      = 6'b000100,
    PH_NAME      = 6'b001000,
    PH_CHUNK_LEN = 6'b010000,
    PH_PAYLOAD   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic        valid;
    event_t      ev;
    logic [7:0]  data;
    logic [63:0] total;
    logic [63:0] size;
    logic [31:0] name_len;
    logic        done;
  } result_t;

endpackage

/* rtl/file_transfer_deframer_core.sv */
// ----------------------------------------------------------------------------
// file_transfer_deframer_core
// Byte-wide deframer for a length-prefixed file transfer stream.
// ----------------------------------------------------------------------------
// Takes one transfer per clock while in_ready is high: a stream byte or an
// abort command. Each byte lands in an input register and is decoded by the
// frame parser once the output register is empty or being emptied; its
// event, if any, is then loaded into the output register. The parser's
// state update sets the rate: one byte every cycle, sustained, as long as
// the output side takes results when they are offered. Frame prefixes and
// length fields yield no output, nor do header bytes before the last; name
// bytes, payload bytes, chunk acknowledges, the header event and errors each
// yield one. Write the magic word only while the block is idle.
// ----------------------------------------------------------------------------
module file_transfer_deframer_core (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        frame_magic_we,
  input  logic [31:0] frame_magic_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  stream_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [7:0]  out_byte,
  output logic [63:0] received_total,
  output logic [63:0] announced_size,
  output logic [31:0] name_length_out,
  output logic        file_done
);

  // Expected magic word; written directly, no handshake.
  logic [31:0] frame_magic;

  // Input register stage.
  logic       s1_valid;
  logic       s1_command;
  logic [7:0] s1_byte;

  // Advance the held byte through the parser whenever the output register
  // is empty or is being emptied this cycle.
  logic             advance;
  ftd_pkg::result_t res;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_magic <= ftd_pkg::FRAME_MAGIC_RESET;
    end else if (frame_magic_we) begin
      frame_magic <= frame_magic_wdata;
    end
  end

  // Hold the accepted transfer until the parser consumes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_command <= command;
      s1_byte    <= stream_byte;
    end
  end

  ftd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .command     (s1_command),
    .stream_byte (s1_byte),
    .frame_magic (frame_magic),
    .res         (res)
  );

  // Output register: load on every parser step, drop a taken result
  // otherwise. Steps that produce no event leave it empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_res       <= res.ev;
      out_byte        <= res.data;
      received_total  <= res.total;
      announced_size  <= res.size;
      name_length_out <= res.name_len;
      file_done       <= res.done;
    end
  end

endmodule

/* rtl/ftd_parser.sv */
// ----------------------------------------------------------------------------
// ftd_parser
// Frame parser state. One step per transfer: decode the byte against the
// current phase, update the state and present the result of that step.
// ----------------------------------------------------------------------------
module ftd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             command,
  input  logic [7:0]       stream_byte,
  input  logic [31:0]      frame_magic,
  output ftd_pkg::result_t res
);

  ftd_pkg::phase_t phase, phase_next;
  logic [3:0]  field_byte_count, field_byte_count_next;
  logic [31:0] magic_shift, magic_shift_next;
  logic [31:0] length_shift, length_shift_next;
  logic [31:0] remaining_bytes, remaining_bytes_next;
  logic [63:0] file_size_reg, file_size_reg_next;
  logic [63:0] total_reg, total_reg_next;
  logic        header_seen, header_seen_next;

  logic        clear_all;
  logic [31:0] len_new;
  logic [63:0] size_new;
  logic [31:0] rem_dec;
  logic [63:0] total_inc;
  logic        done_hit;

  assign len_new   = {length_shift[23:0], stream_byte};
  assign size_new  = {file_size_reg[55:0], stream_byte};
  assign rem_dec   = (remaining_bytes != 32'd0) ? remaining_bytes - 32'd1 : remaining_bytes;
  assign total_inc = (&total_reg) ? total_reg : total_reg + 64'd1;
  assign done_hit  = (file_size_reg != 64'd0) && (total_inc >= file_size_reg);

  always_comb begin
    phase_next            = phase;
    field_byte_count_next = field_byte_count;
    magic_shift_next      = magic_shift;
    length_shift_next     = length_shift;
    remaining_bytes_next  = remaining_bytes;
    file_size_reg_next    = file_size_reg;
    total_reg_next        = total_reg;
    header_seen_next      = header_seen;
    clear_all             = 1'b0;
    res                   = '0;
    res.total             = total_reg;
    res.size              = file_size_reg;

    if (command) begin
      clear_all = 1'b1;
    end else begin
      unique case (phase)
        ftd_pkg::PH_PREFIX: begin
          if (field_byte_count < 4'(ftd_pkg::MAGIC_BYTES)) begin
            magic_shift_next      = {magic_shift[23:0], stream_byte};
            field_byte_count_next = field_byte_count + 4'd1;
          end else if (magic_shift != frame_magic) begin
            res.valid = 1'b1;
            res.ev    = ftd_pkg::EV_BAD_MAGIC;
            clear_all = 1'b1;
          end else if (stream_byte != {7'd0, header_seen}) begin
            res.valid = 1'b1;
            res.ev    = ftd_pkg::EV_BAD_TYPE;
            clear_all = 1'b1;
          end else begin
            field_byte_count_next = 4'd0;
            magic_shift_next      = 32'd0;
            length_shift_next     = 32'd0;
            phase_next = header_seen ? ftd_pkg::PH_CHUNK_LEN : ftd_pkg::PH_NAME_LEN;
          end
        end
        ftd_pkg::PH_NAME_LEN: begin
          length_shift_next = len_new;
          if (field_byte_count >= 4'(ftd_pkg::LEN_BYTES - 1)) begin
            field_byte_count_next = 4'd0;
            file_size_reg_next    = 64'd0;
            phase_next            = ftd_pkg::PH_SIZE;
          end else begin
            field_byte_count_next = field_byte_count + 4'd1;
          end
        end
        ftd_pkg::PH_SIZE: begin
          file_size_reg_next = size_new;
          if (field_byte_count < 4'(ftd_pkg::SIZE_BYTES - 1)) begin
            field_byte_count_next = field_byte_count + 4'd1;
          end else begin
            field_byte_count_next = 4'd0;
            header_seen_next      = 1'b1;
            total_reg_next        = 64'd0;
            remaining_bytes_next  = length_shift;
            phase_next = (length_shift != 32'd0) ? ftd_pkg::PH_NAME : ftd_pkg::PH_PREFIX;
            res.valid    = 1'b1;
            res.ev       = ftd_pkg::EV_HEADER;
            res.total    = 64'd0;
            res.size     = size_new;
            res.name_len = length_shift;
          end
        end
        ftd_pkg::PH_NAME: begin
          remaining_bytes_next = rem_dec;
          if (rem_dec == 32'd0) phase_next = ftd_pkg::PH_PREFIX;
          res.valid = 1'b1;
          res.ev    = ftd_pkg::EV_NAME;
          res.data  = stream_byte;
        end
        ftd_pkg::PH_CHUNK_LEN: begin
          length_shift_next = len_new;
          if (field_byte_count >= 4'(ftd_pkg::LEN_BYTES - 1)) begin
            field_byte_count_next = 4'd0;
            remaining_bytes_next  = len_new;
            phase_next = (len_new != 32'd0) ? ftd_pkg::PH_PAYLOAD : ftd_pkg::PH_PREFIX;
          end else begin
            field_byte_count_next = field_byte_count + 4'd1;
          end
        end
        ftd_pkg::PH_PAYLOAD: begin
          total_reg_next       = total_inc;
          remaining_bytes_next = rem_dec;
          res.valid = 1'b1;
          res.data  = stream_byte;
          res.total = total_inc;
          if (rem_dec != 32'd0) begin
            res.ev = ftd_pkg::EV_PAYLOAD;
          end else begin
            phase_next = ftd_pkg::PH_PREFIX;
            res.ev     = ftd_pkg::EV_ACK;
            res.done   = done_hit;
            clear_all  = done_hit;
          end
        end
        default: begin
          clear_all = 1'b1;
        end
      endcase
    end

    if (clear_all) begin
      phase_next            = ftd_pkg::PH_PREFIX;
      field_byte_count_next = 4'd0;
      magic_shift_next      = 32'd0;
      length_shift_next     = 32'd0;
      remaining_bytes_next  = 32'd0;
      file_size_reg_next    = 64'd0;
      total_reg_next        = 64'd0;
      header_seen_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= ftd_pkg::PH_PREFIX;
      field_byte_count <= 4'd0;
      magic_shift      <= 32'd0;
      length_shift     <= 32'd0;
      remaining_bytes  <= 32'd0;
      file_size_reg    <= 64'd0;
      total_reg        <= 64'd0;
      header_seen      <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      magic_shift      <= magic_shift_next;
      length_shift     <= length_shift_next;
      remaining_bytes  <= remaining_bytes_next;
      file_size_reg    <= file_size_reg_next;
      total_reg        <= total_reg_next;
      header_seen      <= header_seen_next;
    end
  end

endmodule
